@@ sv/ptex_pkg.sv @@
`timescale 1ns / 1ps
package ptex_pkg;

  localparam int EDGE_BITS  = 20;
  localparam int DEPTH_BITS = 12;
  localparam int REPEAT_V   = 3;

  localparam int DIFF_W = 18;
  localparam int PROD_W = 36;
  localparam int EDGE_W = 37;
  localparam int ABS_W  = 37;
  localparam int Z_W    = 32;
  localparam int SH_W   = 5;
  localparam int M_W    = EDGE_BITS + DEPTH_BITS;
  localparam int W_W    = M_W + DEPTH_BITS;
  localparam int D_W    = W_W + 2;
  localparam int UV_W   = 12;
  localparam int P_W    = W_W + UV_W;
  localparam int NU_W   = P_W + 2;
  localparam int NV_W   = NU_W + 2;
  localparam int Q_W    = 14;
  localparam int DIM_W  = 13;

  localparam logic [2:0] REG_VERTEX0  = 3'd0;
  localparam logic [2:0] REG_VERTEX1  = 3'd1;
  localparam logic [2:0] REG_VERTEX2  = 3'd2;
  localparam logic [2:0] REG_TEXCRD0  = 3'd3;
  localparam logic [2:0] REG_TEXCRD1  = 3'd4;
  localparam logic [2:0] REG_TEXCRD2  = 3'd5;
  localparam logic [2:0] REG_TEXDIMS  = 3'd6;

  typedef struct packed {
    logic cov;
    logic deg;
  } ptex_flags_t;

endpackage

@@ sv/ptex_div.sv @@
`timescale 1ns / 1ps
module ptex_div #(
  parameter int NW = 60,
  parameter int DW = 46,
  parameter int QW = 14,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [NW-1:0] rem,
  output logic [SW-1:0] out_side
);
  // Restoring divider, one quotient bit per stage. Requires num < den << QW.
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld_r  [QW];
  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic          v_in;
    logic [NW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] s_in;
    logic [CW-1:0] trial;
    logic [CW-1:0] rext;
    logic [CW-1:0] diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign s_in = side;
    end else begin : g_next
      assign v_in = vld_r[s-1];
      assign r_in = rem_r[s-1];
      assign d_in = den_r[s-1];
      assign q_in = q_r[s-1];
      assign s_in = side_r[s-1];
    end

    assign trial = CW'(d_in) << B;
    assign rext  = CW'(r_in);
    assign ge    = rext >= trial;
    assign diff  = rext - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s]  <= ge ? diff[NW-1:0] : r_in;
        den_r[s]  <= d_in;
        q_r[s]    <= q_in | (QW'(ge) << B);
        side_r[s] <= s_in;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quot      = q_r[QW-1];
  assign rem       = rem_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

@@ sv/ptex_edge.sv @@
`timescale 1ns / 1ps
module ptex_edge #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic [11:0]                        px,
  input  logic [11:0]                        py,
  input  logic [2:0][15:0]                   vx,
  input  logic [2:0][15:0]                   vy,
  output logic                               out_valid,
  output logic [2:0][ptex_pkg::ABS_W-1:0]    out_a,
  output ptex_pkg::ptex_flags_t              out_flags
);
  import ptex_pkg::*;

  logic signed [DIFF_W-1:0] qx, qy;
  logic signed [DIFF_W-1:0] ex [3];
  logic signed [DIFF_W-1:0] ey [3];
  logic signed [DIFF_W-1:0] dqx [3], dqy [3], dax [3], day [3];
  logic signed [DIFF_W-1:0] ar_dx2, ar_dy1, ar_dy2, ar_dx1;
  logic signed [PROD_W-1:0] pa_nxt [3], pb_nxt [3];
  logic signed [PROD_W-1:0] pa_r [3], pb_r [3];
  logic signed [PROD_W-1:0] ara_r, arb_r;
  logic                     ins_r, v1_r;
  logic                     ins;

  logic signed [EDGE_W-1:0] n [3];
  logic signed [EDGE_W-1:0] area;
  logic [ABS_W-1:0]         a_nxt [3];
  logic                     all_pos, all_neg;

  logic                     v2_r;
  logic [ABS_W-1:0]         a_r [3];
  ptex_flags_t              f_r;

  assign qx = $signed({2'b00, px, 4'b0000});
  assign qy = $signed({2'b00, py, 4'b0000});
  assign ins = ({1'b0, px} < 13'(SCREEN_WIDTH)) && ({1'b0, py} < 13'(SCREEN_HEIGHT));

  always_comb begin
    int o, b;
    for (int i = 0; i < 3; i++) begin
      ex[i] = DIFF_W'($signed(vx[i]));
      ey[i] = DIFF_W'($signed(vy[i]));
    end
    // edge i runs from vertex i+1 to vertex i+2, opposite vertex i
    for (int i = 0; i < 3; i++) begin
      o = (i + 1) % 3;
      b = (i + 2) % 3;
      dqx[i] = qx - ex[o];
      dqy[i] = qy - ey[o];
      dax[i] = ex[b] - ex[o];
      day[i] = ey[b] - ey[o];
      pa_nxt[i] = PROD_W'(dqx[i]) * PROD_W'(day[i]);
      pb_nxt[i] = PROD_W'(dqy[i]) * PROD_W'(dax[i]);
    end
  end

  assign ar_dx2 = ex[2] - ex[0];
  assign ar_dy1 = ey[1] - ey[0];
  assign ar_dy2 = ey[2] - ey[0];
  assign ar_dx1 = ex[1] - ex[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= pa_nxt[i];
        pb_r[i] <= pb_nxt[i];
      end
      ara_r <= PROD_W'(ar_dx2) * PROD_W'(ar_dy1);
      arb_r <= PROD_W'(ar_dy2) * PROD_W'(ar_dx1);
      ins_r <= ins;
    end
  end

  always_comb begin
    all_pos = 1'b1;
    all_neg = 1'b1;
    for (int i = 0; i < 3; i++) begin
      n[i]     = EDGE_W'(pa_r[i]) - EDGE_W'(pb_r[i]);
      a_nxt[i] = n[i][EDGE_W-1] ? ABS_W'(-n[i]) : ABS_W'(n[i]);
      all_pos  = all_pos & ~n[i][EDGE_W-1];
      all_neg  = all_neg & n[i][EDGE_W-1];
    end
    area = EDGE_W'(ara_r) - EDGE_W'(arb_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i] <= a_nxt[i];
      end
      f_r.deg <= (area == '0);
      f_r.cov <= (area != '0) && ins_r && (all_pos || all_neg);
    end
  end

  assign out_valid = v2_r;
  assign out_flags = f_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_a[i] = a_r[i];
    end
  end

endmodule

@@ sv/ptex_wgt.sv @@
`timescale 1ns / 1ps
module ptex_wgt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [2:0][ptex_pkg::ABS_W-1:0] in_a,
  input  ptex_pkg::ptex_flags_t           in_flags,
  input  logic [2:0][ptex_pkg::Z_W-1:0]   z,
  input  logic [2:0][ptex_pkg::UV_W-1:0]  u,
  input  logic [2:0][ptex_pkg::UV_W-1:0]  v,
  output logic                            out_valid,
  output logic [ptex_pkg::NU_W-1:0]       nu,
  output logic [ptex_pkg::NV_W-1:0]       nv,
  output logic [ptex_pkg::D_W-1:0]        den,
  output ptex_pkg::ptex_flags_t           out_flags
);
  import ptex_pkg::*;

  localparam int NST = 7;

  logic        vld_r [NST];
  ptex_flags_t flg_r [NST];

  logic [ABS_W-1:0] ora;
  logic [Z_W-1:0]   orz;
  logic [SH_W-1:0]  sa_nxt, sz_nxt;

  logic [ABS_W-1:0]      a3_r [3];
  logic [SH_W-1:0]       sa_r, sz_r;
  logic [EDGE_BITS-1:0]  as_r [3];
  logic [DEPTH_BITS-1:0] zs_r [3];
  logic [M_W-1:0]        m_r [3];
  logic [EDGE_BITS-1:0]  a5_r [3];
  logic [DEPTH_BITS-1:0] zs5_r [3];
  logic [W_W-1:0]        w_r [3];
  logic [EDGE_BITS-1:0]  a6_r [3];
  logic [D_W-1:0]        wsum, asum;
  logic [W_W-1:0]        ws_r [3];
  logic [D_W-1:0]        d7_r, d8_r, d9_r;
  logic [P_W-1:0]        pu_r [3], pv_r [3];
  logic [NU_W-1:0]       nu_r, sv;
  logic [NV_W-1:0]       nv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < NST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flg_r[0] <= in_flags;
      for (int s = 1; s < NST; s++) begin
        flg_r[s] <= flg_r[s-1];
      end
    end
  end

  // shift counts: bit length of the OR equals bit length of the max
  always_comb begin
    ora = in_a[0] | in_a[1] | in_a[2];
    orz = z[0] | z[1] | z[2];
    sa_nxt = '0;
    for (int k = 0; k < ABS_W - EDGE_BITS; k++) begin
      if (ora[EDGE_BITS + k]) sa_nxt = SH_W'(k + 1);
    end
    sz_nxt = '0;
    for (int k = 0; k < Z_W - DEPTH_BITS; k++) begin
      if (orz[DEPTH_BITS + k]) sz_nxt = SH_W'(k + 1);
    end
  end

  always_comb begin
    wsum = D_W'(w_r[0]) + D_W'(w_r[1]) + D_W'(w_r[2]);
    asum = D_W'(a6_r[0]) + D_W'(a6_r[1]) + D_W'(a6_r[2]);
    sv   = NU_W'(pv_r[0]) + NU_W'(pv_r[1]) + NU_W'(pv_r[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a3_r[i] <= in_a[i];
        as_r[i] <= EDGE_BITS'(a3_r[i] >> sa_r);
        zs_r[i] <= DEPTH_BITS'(z[i] >> sz_r);
        a5_r[i] <= as_r[i];
        zs5_r[i] <= zs_r[i];
        a6_r[i] <= a5_r[i];
        // fall back to plain edge weights when the depth weights vanish
        ws_r[i] <= (wsum == '0) ? W_W'(a6_r[i]) : w_r[i];
        pu_r[i] <= P_W'(ws_r[i]) * P_W'(u[i]);
        pv_r[i] <= P_W'(ws_r[i]) * P_W'(v[i]);
      end
      sa_r <= sa_nxt;
      sz_r <= sz_nxt;
      m_r[0] <= M_W'(as_r[0]) * M_W'(zs_r[1]);
      m_r[1] <= M_W'(as_r[1]) * M_W'(zs_r[2]);
      m_r[2] <= M_W'(as_r[2]) * M_W'(zs_r[0]);
      w_r[0] <= W_W'(m_r[0]) * W_W'(zs5_r[2]);
      w_r[1] <= W_W'(m_r[1]) * W_W'(zs5_r[0]);
      w_r[2] <= W_W'(m_r[2]) * W_W'(zs5_r[1]);
      d7_r <= (wsum == '0) ? asum : wsum;
      d8_r <= d7_r;
      d9_r <= d8_r;
      nu_r <= NU_W'(pu_r[0]) + NU_W'(pu_r[1]) + NU_W'(pu_r[2]);
      nv_r <= NV_W'(sv) * NV_W'(REPEAT_V);
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_flags = flg_r[NST-1];
  assign nu        = nu_r;
  assign nv        = nv_r;
  assign den       = d9_r;

endmodule

@@ sv/perspective_texture_rasterizer.sv @@
`timescale 1ns / 1ps
// Perspective-correct triangle pixel test. One pixel request is taken every
// clock unless the output stalls. Each request passes two stages of edge products
// and coverage, seven stages of normalizing and 1/z weighting, fourteen
// stages of a one-bit-per-stage divider for u and v, fourteen more for the
// texture wrap, and the output register that forms the texel address. The
// whole pipeline holds in place while the output request is not taken, so
// input ready is low only while a result waits. Triangle, texture
// coordinates and texture size must be written on the cfg port while no pixel
// is in flight; the block itself does not enforce this.
module perspective_texture_rasterizer #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_covered,
  output logic        out_degenerate,
  output logic [11:0] out_tex_u,
  output logic [11:0] out_tex_v,
  output logic [23:0] out_texel_index
);
  import ptex_pkg::*;

  localparam int FW = $bits(ptex_flags_t);

  logic [63:0] vtx_r [3];
  logic [23:0] tc_r [3];
  logic [25:0] dims_r;

  logic [DIM_W-1:0] width, height;
  logic [2:0][15:0] vx, vy;
  logic [2:0][Z_W-1:0] vz;
  logic [2:0][UV_W-1:0] tu_c, tv_c;

  logic adv;

  logic                      e_valid;
  logic [2:0][ABS_W-1:0]     e_a;
  ptex_flags_t               e_flags;

  logic                      w_valid;
  logic [NU_W-1:0]           w_nu;
  logic [NV_W-1:0]           w_nv;
  logic [D_W-1:0]            w_den;
  ptex_flags_t               w_flags;

  logic                      du_valid, dv_valid;
  logic [Q_W-1:0]            du_q, dv_q;
  logic [NV_W-1:0]           du_rem, dv_rem;
  logic [FW-1:0]             du_side, dv_side;

  logic                      mu_valid, mv_valid;
  logic [Q_W-1:0]            mu_q, mv_q;
  logic [Q_W-1:0]            mu_rem, mv_rem;
  logic [FW+DIM_W-1:0]       mu_side;
  logic [0:0]                mv_side;
  ptex_flags_t               m_flags;
  logic [DIM_W-1:0]          m_width;
  logic [11:0]               fu, fv;

  logic        out_valid_r;
  logic        out_covered_r, out_degenerate_r;
  logic [11:0] out_tex_u_r, out_tex_v_r;
  logic [23:0] out_texel_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        vtx_r[i] <= 64'h0001_0000_0000_0000;
        tc_r[i]  <= '0;
      end
      dims_r <= 26'h020_0100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERTEX0: vtx_r[0] <= cfg_data;
        REG_VERTEX1: vtx_r[1] <= cfg_data;
        REG_VERTEX2: vtx_r[2] <= cfg_data;
        REG_TEXCRD0: tc_r[0]  <= cfg_data[23:0];
        REG_TEXCRD1: tc_r[1]  <= cfg_data[23:0];
        REG_TEXCRD2: tc_r[2]  <= cfg_data[23:0];
        REG_TEXDIMS: dims_r   <= cfg_data[25:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i]   = vtx_r[i][15:0];
      vy[i]   = vtx_r[i][31:16];
      vz[i]   = vtx_r[i][63:32];
      tu_c[i] = tc_r[i][11:0];
      tv_c[i] = tc_r[i][23:12];
    end
    width  = dims_r[12:0];
    height = dims_r[25:13];
    if (width == '0) width = DIM_W'(1);
    else if (width > DIM_W'(4096)) width = DIM_W'(4096);
    if (height == '0) height = DIM_W'(1);
    else if (height > DIM_W'(4096)) height = DIM_W'(4096);
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  ptex_edge #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .px       (in_pixel_x),
    .py       (in_pixel_y),
    .vx       (vx),
    .vy       (vy),
    .out_valid(e_valid),
    .out_a    (e_a),
    .out_flags(e_flags)
  );

  ptex_wgt u_wgt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (e_valid),
    .in_a     (e_a),
    .in_flags (e_flags),
    .z        (vz),
    .u        (tu_c),
    .v        (tv_c),
    .out_valid(w_valid),
    .nu       (w_nu),
    .nv       (w_nv),
    .den      (w_den),
    .out_flags(w_flags)
  );

  ptex_div #(.NW(NV_W), .DW(D_W), .QW(Q_W), .SW(FW)) u_div_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (w_valid),
    .num      (NV_W'(w_nu)),
    .den      (w_den),
    .side     (w_flags),
    .out_valid(du_valid),
    .quot     (du_q),
    .rem      (du_rem),
    .out_side (du_side)
  );

  ptex_div #(.NW(NV_W), .DW(D_W), .QW(Q_W), .SW(FW)) u_div_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (w_valid),
    .num      (w_nv),
    .den      (w_den),
    .side     (w_flags),
    .out_valid(dv_valid),
    .quot     (dv_q),
    .rem      (dv_rem),
    .out_side (dv_side)
  );

  // texture wrap: remainder of the quotient by the texture size
  ptex_div #(.NW(Q_W), .DW(DIM_W), .QW(Q_W), .SW(FW + DIM_W)) u_mod_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (du_valid),
    .num      (du_q),
    .den      (width),
    .side     ({du_side, width}),
    .out_valid(mu_valid),
    .quot     (mu_q),
    .rem      (mu_rem),
    .out_side (mu_side)
  );

  ptex_div #(.NW(Q_W), .DW(DIM_W), .QW(Q_W), .SW(1)) u_mod_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (dv_valid),
    .num      (dv_q),
    .den      (height),
    .side     (dv_side[FW-1]),
    .out_valid(mv_valid),
    .quot     (mv_q),
    .rem      (mv_rem),
    .out_side (mv_side)
  );

  assign m_flags = mu_side[FW+DIM_W-1:DIM_W];
  assign m_width = mu_side[DIM_W-1:0];
  assign fu      = m_flags.cov ? mu_rem[11:0] : 12'd0;
  assign fv      = m_flags.cov ? mv_rem[11:0] : 12'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mu_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_covered_r     <= m_flags.cov;
      out_degenerate_r  <= m_flags.deg;
      out_tex_u_r       <= fu;
      out_tex_v_r       <= fv;
      out_texel_index_r <= 24'(fu) + 24'(fv) * 24'(m_width);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_covered     = out_covered_r;
  assign out_degenerate  = out_degenerate_r;
  assign out_tex_u       = out_tex_u_r;
  assign out_tex_v       = out_tex_v_r;
  assign out_texel_index = out_texel_index_r;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (du_valid == dv_valid) && (mu_valid == mv_valid)
    && (!du_valid || (du_side[FW-1] == dv_side[FW-1]))
    && (!mu_valid || (mv_side[0] == m_flags.cov)))
    else $error("u and v lanes out of step");

  a_deg_not_cov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_covered)
    else $error("degenerate triangle reported as covered");

  a_uncov_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_covered |-> (out_tex_u == '0) && (out_tex_v == '0)
    && (out_texel_index == '0))
    else $error("uncovered pixel has texture data");

  a_wrap_u: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_covered |-> (13'(out_tex_u) < width) && (13'(out_tex_v) < height))
    else $error("texture coordinate not wrapped");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    mu_valid && m_flags.cov |-> (mu_q <= Q_W'(12287)) && (mv_q <= Q_W'(12287)))
    else $error("texture quotient out of range");

endmodule
